/* design/lss_pkg.sv */
package lss_pkg;

	// One held sprite entry
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] flags;
	} entry_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;  // place the new entry, shift larger x one cell right
		logic drain;   // shift every entry one cell left toward the output
	} cell_ctl_t;

	// Scan/emit sequencer
	typedef enum logic [1:0] {
		ST_SCAN = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	localparam logic [7:0] LINE_OFFSET = 8'd16;
	localparam logic [4:0] HEIGHT_RESET = 5'd8;

endpackage

/* design/line_sprite_select_sorted_unit.sv */
// An entry is sorted into the cell chain in the same cycle that it is taken.
// After the entry marked last, the list appears on the next cycle, one result per cycle
// while out_stall is low; count results (one if the list is empty), shifted out of cell 0.
// Throughput: one entry per cycle while scanning; input stalls during the emit phase.
// Reset (arst_n low, asynchronous): list empty, scan state, sprite height 8.
// Held entries are not cleared; only the fill count marks them valid.
module line_sprite_select_sorted_unit #(
	parameter int MAX_PER_LINE = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] line,
	input  logic [7:0] obj_y,
	input  logic [7:0] obj_x,
	input  logic [7:0] obj_tile,
	input  logic [7:0] obj_flags,
	input  logic       last_entry,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] slot,
	output logic [7:0] sel_y,
	output logic [7:0] sel_x,
	output logic [7:0] sel_tile,
	output logic [7:0] sel_flags,
	output logic [3:0] sel_count,
	output logic       last_of_line
);
	import lss_pkg::*;

	localparam int CW = $clog2(MAX_PER_LINE + 1);

	state_t          state_q;
	logic [4:0]      height_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   slot_q;
	logic [4:0]      count_ext;
	logic [4:0]      slot_ext;
	entry_t          new_e;
	cell_ctl_t       ctl;
	logic            in_acc;
	logic            out_acc;
	logic            hit;
	logic [8:0]      target;
	logic            done;
	entry_t          e_arr [MAX_PER_LINE];
	logic            below_arr [MAX_PER_LINE];

	assign new_e = '{y: obj_y, x: obj_x, tile: obj_tile, flags: obj_flags};

	// visibility test, 9-bit sums
	assign target = {1'b0, line} + {1'b0, LINE_OFFSET};
	assign hit = (obj_x != 8'd0) && (count_q < CW'(MAX_PER_LINE)) &&
		({1'b0, obj_y} <= target) &&
		(({1'b0, obj_y} + {4'd0, height_q}) > target);

	// handshakes
	assign in_stall  = (state_q != ST_SCAN);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign done      = (count_q == '0) || (slot_q + CW'(1) == count_q);

	assign ctl.insert = in_acc && hit;
	assign ctl.drain  = out_acc && (count_q != '0);

	// cell chain
	for (genvar i = 0; i < MAX_PER_LINE; i++) begin : g_cell
		entry_t left_e;
		logic   left_below;
		entry_t right_e;
		if (i == 0) begin : g_first
			assign left_e     = new_e;
			assign left_below = 1'b1;
		end else begin : g_mid
			assign left_e     = e_arr[i-1];
			assign left_below = below_arr[i-1];
		end
		if (i == MAX_PER_LINE - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = e_arr[i+1];
		end
		lss_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk       (clk),
			.count     (count_q),
			.ctl       (ctl),
			.new_e     (new_e),
			.left_e    (left_e),
			.left_below(left_below),
			.right_e   (right_e),
			.e_q       (e_arr[i]),
			.below     (below_arr[i])
		);
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			height_q <= cfg_wdata;
		end
	end

	// sequencer, fill count and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
			count_q <= '0;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_SCAN: begin
					if (in_acc) begin
						if (hit) begin
							count_q <= count_q + CW'(1);
						end
						if (last_entry) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (done) begin
							state_q <= ST_SCAN;
							count_q <= '0;
							slot_q  <= '0;
						end else begin
							slot_q <= slot_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_SCAN;
				end
			endcase
		end
	end

	// entry fields come from cell 0 (zero for an empty list); slot, count and last from the counters
	assign count_ext    = 5'(count_q);
	assign slot_ext     = 5'(slot_q);
	assign slot         = slot_ext[3:0];
	assign sel_count    = count_ext[3:0];
	assign last_of_line = done;
	assign sel_y        = (count_q == '0) ? 8'd0 : e_arr[0].y;
	assign sel_x        = (count_q == '0) ? 8'd0 : e_arr[0].x;
	assign sel_tile     = (count_q == '0) ? 8'd0 : e_arr[0].tile;
	assign sel_flags    = (count_q == '0) ? 8'd0 : e_arr[0].flags;

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PER_LINE))
		else $error("fill count above list depth");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count_q != '0) |-> (slot_q < count_q))
		else $error("slot beyond list");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_of_line) |=> (count_q == '0 && !out_valid && slot_q == '0))
		else $error("list not cleared after final result");

	a_no_insert_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !ctl.insert)
		else $error("insert during emit");

endmodule

/* design/lss_cell.sv */
module lss_cell #(
	parameter int IDX = 0,
	parameter int CW = 4
) (
	input  logic              clk,
	input  logic [CW-1:0]     count,
	input  lss_pkg::cell_ctl_t ctl,
	input  lss_pkg::entry_t   new_e,
	input  lss_pkg::entry_t   left_e,
	input  logic              left_below,
	input  lss_pkg::entry_t   right_e,
	output lss_pkg::entry_t   e_q,
	output logic              below
);
	import lss_pkg::*;

	logic occupied;

	// cell is part of the list when its index is under the fill count
	assign occupied = CW'(IDX) < count;
	// new entry sorts after this one (ties keep scan order)
	assign below = occupied && (e_q.x <= new_e.x);

	// insert: first cell not below takes the new entry, later ones take left neighbor
	// drain: take right neighbor
	always_ff @(posedge clk) begin
		if (ctl.insert && !below) begin
			e_q <= left_below ? new_e : left_e;
		end else if (ctl.drain) begin
			e_q <= right_e;
		end
	end

endmodule

/* tb/tb_line_sprite_select_sorted_unit.sv */
module tb_line_sprite_select_sorted_unit;
	import lss_pkg::*;

	localparam int LIST_DEPTH  = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_PCT    = 38;

	// One expected list slot
	typedef struct {
		logic [3:0] slot;
		entry_t     obj;
		logic [3:0] count;
		logic       last;
	} sel_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] line;
	logic [7:0] obj_y;
	logic [7:0] obj_x;
	logic [7:0] obj_tile;
	logic [7:0] obj_flags;
	logic       last_entry;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] slot;
	logic [7:0] sel_y;
	logic [7:0] sel_x;
	logic [7:0] sel_tile;
	logic [7:0] sel_flags;
	logic [3:0] sel_count;
	logic       last_of_line;

	// Predicted line list and height
	entry_t      held [LIST_DEPTH];
	int          held_count;
	logic [4:0]  obj_height;
	sel_result_t expected_sel [$];

	int errors    = 0;
	int n_entries = 0;
	int n_results = 0;
	int n_lines   = 0;
	int n_empty   = 0;
	int n_full    = 0;
	bit steady    = 0;
	int hold_ask  = 0;
	int hold_left = 0;

	line_sprite_select_sorted_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.line        (line),
		.obj_y       (obj_y),
		.obj_x       (obj_x),
		.obj_tile    (obj_tile),
		.obj_flags   (obj_flags),
		.last_entry  (last_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slot        (slot),
		.sel_y       (sel_y),
		.sel_x       (sel_x),
		.sel_tile    (sel_tile),
		.sel_flags   (sel_flags),
		.sel_count   (sel_count),
		.last_of_line(last_of_line)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Scan one entry into the predicted list; on the last entry, emit and clear
	task automatic select_entry(input logic [7:0] ln, input entry_t e, input logic last);
		int          target;
		int          pos;
		sel_result_t r;
		target = int'(ln) + int'(LINE_OFFSET);
		if (e.x != 8'd0 && held_count < LIST_DEPTH && int'(e.y) <= target &&
				int'(e.y) + int'(obj_height) > target) begin
			pos = held_count;
			// equal x goes behind, so scan order holds
			while (pos > 0 && held[pos - 1].x > e.x)
				pos--;
			for (int i = held_count; i > pos; i--)
				held[i] = held[i - 1];
			held[pos] = e;
			held_count++;
		end
		if (!last)
			return;
		n_lines++;
		if (held_count == 0) begin
			r.slot  = 4'd0;
			r.obj   = '0;
			r.count = 4'd0;
			r.last  = 1'b1;
			expected_sel.push_back(r);
			n_empty++;
		end else begin
			if (held_count == LIST_DEPTH)
				n_full++;
			for (int k = 0; k < held_count; k++) begin
				r.slot  = 4'(k);
				r.obj   = held[k];
				r.count = 4'(held_count);
				r.last  = (k == held_count - 1);
				expected_sel.push_back(r);
			end
		end
		held_count = 0;
	endtask

	// Offer one request and wait until it is taken; valid stays up for the next one
	task automatic send_entry(input logic [7:0] ln, y, x, tile, flags, input logic last);
		bit taken;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		line       <= ln;
		obj_y      <= y;
		obj_x      <= x;
		obj_tile   <= tile;
		obj_flags  <= flags;
		last_entry <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end
		select_entry(ln, {y, x, tile, flags}, last);
		n_entries++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_sel.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_height(input logic [4:0] h);
		cfg_we    <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we     <= 1'b0;
		obj_height = h;
	endtask

	// One scan: mostly entries that fall on the line, some hidden, misses and stray lines
	task automatic send_random_line(output int sent);
		logic [7:0] ln;
		logic [7:0] ln_item;
		logic [7:0] y;
		logic [7:0] x;
		int         len;
		int         target;
		int         reach;
		int         pick;
		ln     = 8'($urandom_range(0, 255));
		len    = ($urandom_range(9) == 0) ? $urandom_range(11, 16) :
			$urandom_range(1, 10);
		target = int'(ln) + 16;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 70 && obj_height != 5'd0) begin
				reach = target - int'($urandom_range(0, obj_height - 1));
				y = (reach > 255) ? 8'd255 : 8'(reach);
			end else begin
				y = 8'($urandom);
			end
			pick = $urandom_range(99);
			if (pick < 8)
				x = 8'd0;
			else if (pick < 30)
				x = 8'($urandom_range(1, 4) * 8);  // collide on x
			else
				x = 8'($urandom_range(1, 255));
			ln_item = ($urandom_range(15) == 0) ? 8'($urandom) : ln;
			send_entry(ln_item, y, x, 8'($urandom), 8'($urandom), i == len - 1);
		end
		sent = len;
	endtask

	// Top and bottom rows, just outside both, hidden entry, field extremes, empty line
	task automatic test_row_bounds();
		send_entry(8'd40, 8'd56, 8'd255, 8'd0,   8'd255, 1'b0);
		send_entry(8'd40, 8'd49, 8'd1,   8'd255, 8'd0,   1'b0);
		send_entry(8'd40, 8'd48, 8'd7,   8'd12,  8'd34,  1'b0);
		send_entry(8'd40, 8'd57, 8'd9,   8'd56,  8'd78,  1'b0);
		send_entry(8'd40, 8'd50, 8'd0,   8'd90,  8'd12,  1'b0);
		send_entry(8'd40, 8'd0,  8'd128, 8'hA5,  8'h5A,  1'b1);
		send_entry(8'd0,  8'd0,  8'd3,   8'd1,   8'd2,   1'b1);
	endtask

	// Same x keeps scan order behind equal entries
	task automatic test_equal_x();
		send_entry(8'd100, 8'd110, 8'd60, 8'd1, 8'd11, 1'b0);
		send_entry(8'd100, 8'd112, 8'd60, 8'd2, 8'd22, 1'b0);
		send_entry(8'd100, 8'd116, 8'd20, 8'd3, 8'd33, 1'b0);
		send_entry(8'd100, 8'd111, 8'd60, 8'd4, 8'd44, 1'b1);
	endtask

	// Twelve visible entries in falling x: the list fills, the rest is dropped
	task automatic test_full_list();
		for (int i = 0; i < 12; i++)
			send_entry(8'd200, 8'd210, 8'(200 - 15 * i), 8'(i), 8'(i + 100), i == 11);
	endtask

	// Tall objects at the bottom line, zero height, widest height
	task automatic test_height_extremes();
		wait_drained();
		set_height(5'd16);
		send_entry(8'd254, 8'd255, 8'd9, 8'd77, 8'd88, 1'b1);
		wait_drained();
		set_height(5'd0);
		send_entry(8'd60, 8'd76, 8'd5, 8'd1, 8'd1, 1'b1);
		wait_drained();
		set_height(5'd31);
		send_entry(8'd255, 8'd241, 8'd30, 8'd3, 8'd4, 1'b0);
		send_entry(8'd255, 8'd240, 8'd31, 8'd5, 8'd6, 1'b1);
	endtask

	// Receiver holds off while a full line and the next scan are pushed in
	task automatic test_backpressure();
		wait_drained();
		set_height(5'd8);
		steady   = 1'b1;
		hold_ask = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_entry(8'd80, 8'd90, 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
				i == 11);
		for (int i = 0; i < 6; i++)
			send_entry(8'd81, 8'd92, 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
				i == 5);
		steady = 1'b0;
		wait_drained();
	endtask

	// Random scans across several heights, one phase without idling
	task automatic test_random_lines();
		logic [4:0] heights [4];
		int         sent;
		int         total;
		heights = '{5'd8, 5'd16, 5'($urandom_range(0, 31)), 5'd8};
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			set_height(heights[p]);
			steady = (p == 1);
			total  = 0;
			while (total < 55) begin
				send_random_line(sent);
				total += sent;
			end
		end
		steady = 1'b0;
		wait_drained();
	endtask

	// Receiver stall: a requested long hold, otherwise random, or none while steady
	always @(posedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Result check; a result seen here with stall low is taken at the next edge
	always @(negedge clk) begin : sel_check
		sel_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_results++;
			if (expected_sel.size() == 0) begin
				flag_mismatch($sformatf("unexpected result slot %0d x %0d count %0d",
					slot, sel_x, sel_count));
			end else begin
				want = expected_sel.pop_front();
				if (slot !== want.slot || sel_y !== want.obj.y || sel_x !== want.obj.x ||
						sel_tile !== want.obj.tile || sel_flags !== want.obj.flags ||
						sel_count !== want.count || last_of_line !== want.last)
					flag_mismatch($sformatf({"got slot %0d y %0d x %0d t %0d f %0d n %0d",
						" l %0d, want %0d %0d %0d %0d %0d %0d %0d"},
						slot, sel_y, sel_x, sel_tile, sel_flags, sel_count, last_of_line,
						want.slot, want.obj.y, want.obj.x, want.obj.tile, want.obj.flags,
						want.count, want.last));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 5'd0;
		in_valid   = 1'b0;
		line       = 8'd0;
		obj_y      = 8'd0;
		obj_x      = 8'd0;
		obj_tile   = 8'd0;
		obj_flags  = 8'd0;
		last_entry = 1'b0;
		out_stall  = 1'b0;
		held_count = 0;
		obj_height = HEIGHT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_row_bounds();
		test_equal_x();
		test_full_list();
		test_height_extremes();
		test_backpressure();
		test_random_lines();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Scanned %0d entries in %0d lines; %0d results checked",
			n_entries, n_lines, n_results);
		$display("%0d full and %0d empty lists, heights 0 to 31, long output hold, %0d mismatches",
			n_full, n_empty, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
